>>> hw/rtl/four_way_hash_table_replacement_core_macros.svh
// Assertion macros used by the hash table sequencer (fwht_ctrl).
`ifndef FOUR_WAY_HASH_TABLE_REPLACEMENT_CORE_MACROS_SVH
`define FOUR_WAY_HASH_TABLE_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FWHT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("fwht check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FWHT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("fwht check failed");

`endif

>>> hw/rtl/fwht_pkg.sv
// Package: constants, codes, types and helpers of the hash table core.
`default_nettype none
package fwht_pkg;

  localparam int CLUSTERS    = 4096;  // power of two: the cluster index is the low key bits
  localparam int WAYS        = 4;
  localparam int CL_AW       = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int WAY_AW      = $clog2(WAYS);
  localparam int ENTRY_W     = 64;
  localparam int ROW_W       = WAYS * ENTRY_W;
  localparam int TAG_LSB     = 48;
  localparam int TAG_W       = ENTRY_W - TAG_LSB;
  localparam int FILL_W      = 15;
  localparam int PROD_W      = FILL_W + 8;
  localparam int FULL_MUL    = 250;
  localparam int FULL_MAX    = 1000;
  localparam int YOUNG_BONUS = 512;
  localparam int SCORE_INIT  = 1024;
  localparam int SCORE_W     = 11;

  localparam logic [7:0]        AGE_MASK = 8'hfc;
  localparam logic [7:0]        GEN_STEP = 8'h04;
  localparam logic [FILL_W-1:0] FILL_MAX = 15'h7fff;

  typedef enum logic [1:0] {
    OP_PROBE  = 2'd0,
    OP_INSERT = 2'd1,
    OP_GEN    = 2'd2,
    OP_CLEAR  = 2'd3
  } fwht_op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS
  } fwht_state_t;

  // Request context held for the resolve cycle.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [ENTRY_W-1:0] enc;
    logic [7:0]         gen;
  } fwht_req_t;

  // Outcome of resolving one cluster row.
  typedef struct packed {
    logic               hit;
    logic [ENTRY_W-1:0] hit_entry;
    logic               fill;
    logic [ROW_W-1:0]   row_wr;
  } fwht_sel_t;

  // 250 * filled / CLUSTERS, capped at 1000.
  function automatic logic [9:0] fullness_of(input logic [FILL_W-1:0] f);
    logic [PROD_W-1:0] p;
    logic [PROD_W-1:0] q;
    p = PROD_W'(FULL_MUL) * PROD_W'(f);
    q = p >> CL_AW;
    return (q > PROD_W'(FULL_MAX)) ? 10'(FULL_MAX) : q[9:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fwht_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
`default_nettype none
module fwht_ram #(
  parameter int W = 8,
  parameter int D = 2
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [$clog2(D)-1:0]  waddr,
  input  wire logic [W-1:0]          wdata,
  input  wire logic                  re,
  input  wire logic [$clog2(D)-1:0]  raddr,
  output logic      [W-1:0]          rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fwht_way_sel.sv
// Way resolution: tag match, depth/age victim choice and row merge.
`default_nettype none
module fwht_way_sel import fwht_pkg::*; (
  input  wire logic [ROW_W-1:0] row,
  input  wire fwht_req_t        req,
  output fwht_sel_t             sel
);

  always_comb begin
    logic [ENTRY_W-1:0] way [WAYS];
    logic [7:0]         d   [WAYS];
    logic [SCORE_W-1:0] sc  [WAYS];
    logic               found;
    logic [WAY_AW-1:0]  mw;
    logic [WAY_AW-1:0]  victim;
    logic [SCORE_W-1:0] least;
    logic [WAY_AW-1:0]  wsel;

    found  = 1'b0;
    mw     = '0;
    victim = '0;
    least  = SCORE_W'(SCORE_INIT);
    for (int w = 0; w < WAYS; w++) begin
      way[w] = row[w*ENTRY_W +: ENTRY_W];
      d[w]   = way[w][7:0];
      sc[w]  = {{(SCORE_W-8){1'b0}}, d[w]};
      // current-generation entries score higher and survive longer
      if (d[w] != 8'd0 && (way[w][15:8] & AGE_MASK) == req.gen) begin
        sc[w] = sc[w] + SCORE_W'(YOUNG_BONUS);
      end
    end
    // first matching tag wins
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (way[w][ENTRY_W-1:TAG_LSB] == req.tag) begin
        found = 1'b1;
        mw    = WAY_AW'(w);
      end
    end
    // least score, ties to the lowest way
    for (int w = 0; w < WAYS; w++) begin
      if (sc[w] < least) begin
        least  = sc[w];
        victim = WAY_AW'(w);
      end
    end

    wsel          = found ? mw : victim;
    sel.hit       = found && (d[mw] != 8'd0);
    sel.hit_entry = way[mw];
    sel.fill      = found ? (d[mw] == 8'd0) : (least == '0);
    sel.row_wr    = row;
    sel.row_wr[wsel*ENTRY_W +: ENTRY_W] = req.enc;
  end

endmodule
`default_nettype wire

>>> hw/rtl/fwht_ctrl.sv
// Sequencer: request capture, clearing sweep, write-back and result registers.
`default_nettype none
`include "four_way_hash_table_replacement_core_macros.svh"
module fwht_ctrl import fwht_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_op,
  input  wire logic [63:0]         in_key,
  input  wire logic [15:0]         in_move_code,
  input  wire logic signed [15:0]  in_score_in,
  input  wire logic [1:0]          in_bound_in,
  input  wire logic signed [8:0]   in_depth_in,
  output logic                     ram_we,
  output logic [CL_AW-1:0]         ram_waddr,
  output logic [ROW_W-1:0]         ram_wdata,
  output logic                     ram_re,
  output logic [CL_AW-1:0]         ram_raddr,
  output fwht_req_t                req,
  input  wire fwht_sel_t           sel,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic [15:0]              out_move_out,
  output logic signed [15:0]       out_score_out,
  output logic [1:0]               out_bound_out,
  output logic [7:0]               out_depth_out,
  output logic [9:0]               out_fullness
);

  fwht_state_t       state_r, state_nxt;
  logic [CL_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [7:0]        gen_r, gen_nxt;
  logic [FILL_W-1:0] filled_r, filled_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  fwht_op_t          op_r;
  logic [CL_AW-1:0]  idx_r;
  fwht_req_t         req_r;
  logic [15:0]       move_r;
  logic [15:0]       score_r;
  logic [1:0]        bound_r;
  logic [7:0]        depth_r;
  logic [9:0]        full_r;
  logic              accept;
  logic              last_row;
  logic              do_insert;

  assign accept    = start && (state_r == ST_IDLE);
  assign last_row  = (clr_cnt_r == CL_AW'(CLUSTERS - 1));
  assign do_insert = (state_r == ST_ACCESS) && (op_r == OP_INSERT);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (last_row) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (fwht_op_t'(in_op))
            OP_PROBE:  state_nxt = ST_ACCESS;
            OP_INSERT: state_nxt = ST_ACCESS;
            OP_CLEAR:  state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ACCESS: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // outputs and memory control
  always_comb begin
    busy      = (state_r != ST_IDLE);
    ram_re    = accept;
    ram_raddr = in_key[CL_AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = sel.row_wr;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      ST_ACCESS: ram_we = (op_r == OP_INSERT);
      ST_IDLE:   ram_we = 1'b0;
      default:   ram_we = 1'b0;
    endcase
  end

  // state updates
  always_comb begin
    clr_cnt_nxt = (state_r == ST_CLEAR) ? clr_cnt_r + CL_AW'(1) : '0;
    gen_nxt     = gen_r;
    filled_nxt  = filled_r;
    if (accept && fwht_op_t'(in_op) == OP_GEN) begin
      gen_nxt = gen_r + GEN_STEP;
    end
    if (accept && fwht_op_t'(in_op) == OP_CLEAR) begin
      filled_nxt = '0;
    end else if (do_insert && sel.fill && filled_r != FILL_MAX) begin
      filled_nxt = filled_r + FILL_W'(1);
    end
    out_valid_nxt = (state_r == ST_ACCESS) ||
                    (accept && (fwht_op_t'(in_op) == OP_GEN ||
                                fwht_op_t'(in_op) == OP_CLEAR));
    out_hit_nxt   = (state_r == ST_ACCESS) && (op_r == OP_PROBE) && sel.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      gen_r       <= '0;
      filled_r    <= '0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      gen_r       <= gen_nxt;
      filled_r    <= filled_nxt;
      out_valid_r <= out_valid_nxt;
      out_hit_r   <= out_hit_nxt;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= fwht_op_t'(in_op);
      idx_r     <= in_key[CL_AW-1:0];
      req_r.tag <= in_key[63:TAG_LSB];
      req_r.gen <= gen_r;
      req_r.enc <= {in_key[63:TAG_LSB], in_move_code, in_score_in,
                    gen_r | {6'b0, in_bound_in}, in_depth_in[7:0] + 8'd1};
    end
    move_r  <= out_hit_nxt ? sel.hit_entry[47:32] : '0;
    score_r <= out_hit_nxt ? sel.hit_entry[31:16] : '0;
    bound_r <= out_hit_nxt ? sel.hit_entry[9:8] : '0;
    depth_r <= out_hit_nxt ? sel.hit_entry[7:0] - 8'd1 : '0;
    full_r  <= fullness_of(filled_nxt);
  end

  assign req           = req_r;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_move_out  = move_r;
  assign out_score_out = score_r;
  assign out_bound_out = bound_r;
  assign out_depth_out = depth_r;
  assign out_fullness  = full_r;

  `FWHT_ASSERT_IMP(a_hit_strobed, out_hit_r, out_valid_r)
  `FWHT_ASSERT_NXT(a_access_result, state_r == ST_ACCESS, out_valid_r && state_r == ST_IDLE)
  `FWHT_ASSERT_IMP(a_write_owner, ram_we, state_r == ST_ACCESS || state_r == ST_CLEAR)
  `FWHT_ASSERT_NXT(a_clear_empties, accept && in_op == OP_CLEAR, filled_r == '0 && out_fullness == '0)

endmodule
`default_nettype wire

>>> hw/rtl/four_way_hash_table_replacement_core.sv
// Top level of the four-way hash table core with depth/age replacement.
// A probe or insert reads the cluster row (four 64-bit ways) from the single row memory
// in the accept cycle; the row is resolved and, for an insert, written back in the next,
// and its result strobes on out_valid in the cycle after that. A clear, and the pass that
// follows reset, sweeps the memory one row per cycle over all CLUSTERS (4096) rows with
// busy high; the clear's result strobes right after its accept. Each result is on the
// out_ ports for one cycle only and cannot be stalled.
`default_nettype none
module four_way_hash_table_replacement_core import fwht_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_op,
  input  wire logic [63:0]         in_key,
  input  wire logic [15:0]         in_move_code,
  input  wire logic signed [15:0]  in_score_in,
  input  wire logic [1:0]          in_bound_in,
  input  wire logic signed [8:0]   in_depth_in,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic [15:0]              out_move_out,
  output logic signed [15:0]       out_score_out,
  output logic [1:0]               out_bound_out,
  output logic [7:0]               out_depth_out,
  output logic [9:0]               out_fullness
);

  logic             ram_we;
  logic [CL_AW-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic             ram_re;
  logic [CL_AW-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_rdata;
  fwht_req_t        req;
  fwht_sel_t        sel;

  fwht_ram #(
    .W (ROW_W),
    .D (CLUSTERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fwht_way_sel u_way_sel (
    .row (ram_rdata),
    .req (req),
    .sel (sel)
  );

  fwht_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_move_code  (in_move_code),
    .in_score_in   (in_score_in),
    .in_bound_in   (in_bound_in),
    .in_depth_in   (in_depth_in),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .req           (req),
    .sel           (sel),
    .out_valid     (out_valid),
    .out_hit       (out_hit),
    .out_move_out  (out_move_out),
    .out_score_out (out_score_out),
    .out_bound_out (out_bound_out),
    .out_depth_out (out_depth_out),
    .out_fullness  (out_fullness)
  );

endmodule
`default_nettype wire
